[rtl/biou_pkg.sv]
// shared types, constants and helpers for the best iou region match block
package biou_pkg;

    // table depth and fixed-point fraction width
    localparam int NUM_REGIONS = 32;
    localparam int FRAC_BITS   = 15;

    // field saturation limit: 1.0, capped at the 16-bit field range
    localparam logic [15:0] SAT_LIM = (FRAC_BITS < 15) ? 16'(1 << FRAC_BITS) : 16'd32768;

    // opcodes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QAREA,
        ST_EDGE,
        ST_MUL_INT,
        ST_MUL_AREA,
        ST_UNION,
        ST_MUL_LHS,
        ST_MUL_RHS,
        ST_CMP,
        ST_STORE
    } state_t;

    // clamp an edge or size to the saturation limit
    function automatic logic [15:0] sat_field(input logic [15:0] v);
        return (v > SAT_LIM) ? SAT_LIM : v;
    endfunction

endpackage

[rtl/best_iou_region_match.sv]
// Best IoU region match: a load writes one table entry, a query returns the best entry.
// A query is accepted only while the sequencer is idle; it first forms its own area, then walks the
// effective region count entry by entry and holds its result in ST_STORE until the output register is free.
// For each table entry the single shared 32x32 multiplier forms four products in turn (intersection,
// entry area and two cross products); a load is taken while idle and writes its entry at once.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, region_count = 32;
// table contents stay undefined until loaded.
module best_iou_region_match #(
    parameter int NUM_REGIONS = biou_pkg::NUM_REGIONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: region_count
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_index, rect_left, rect_top, rect_width, rect_height
    input  logic        s_tuser,   // opcode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // best_region, best_intersection, best_union
);

    localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int CNT_W = $clog2(NUM_REGIONS + 1) + 1;

    // input field unpacking
    logic [4:0]  in_index;
    logic [15:0] in_left;
    logic [15:0] in_top;
    logic [15:0] in_width;
    logic [15:0] in_height;
    logic        s_xfer;

    assign in_index  = s_tdata[4:0];
    assign in_left   = s_tdata[20:5];
    assign in_top    = s_tdata[36:21];
    assign in_width  = s_tdata[52:37];
    assign in_height = s_tdata[68:53];
    assign s_xfer    = s_tvalid && s_tready;

    biou_pkg::state_t state_reg;
    biou_pkg::state_t state_next;

    logic [5:0]       region_count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] last_reg;

    // region table and its registered read port
    logic [63:0] region_mem [NUM_REGIONS];
    logic [63:0] rd_data_reg;

    // query rectangle, saturated
    logic [15:0] ql_reg, qt_reg, qw_reg, qh_reg;
    logic [30:0] qarea_reg;

    // per-entry working registers
    logic [15:0] ew_reg, eh_reg;
    logic [16:0] iw_reg, ih_reg;
    logic [30:0] inter_reg;
    logic [30:0] earea_reg;
    logic [31:0] uni_reg;
    logic [30:0] num_reg;
    logic [31:0] den_reg;
    logic [62:0] lhs_reg;
    logic [62:0] rhs_reg;

    // running best
    logic [IDX_W-1:0] best_reg;
    logic [30:0]      best_int_reg;
    logic [31:0]      best_uni_reg;
    logic [30:0]      best_num_reg;
    logic [31:0]      best_den_reg;

    // result holding register
    logic        m_valid_reg;
    logic [67:0] out_data_reg;
    logic        out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, out_data_reg};

    // effective entry count for a new query
    logic [CNT_W-1:0] count_eff;
    always_comb begin
        if (region_count_reg == 6'd0) begin
            count_eff = CNT_W'(1);
        end else if (CNT_W'(region_count_reg) > CNT_W'(NUM_REGIONS)) begin
            count_eff = CNT_W'(NUM_REGIONS);
        end else begin
            count_eff = CNT_W'(region_count_reg);
        end
    end

    // stored entry fields, saturated
    logic [15:0] el, et, ew, eh;
    assign el = biou_pkg::sat_field(rd_data_reg[15:0]);
    assign et = biou_pkg::sat_field(rd_data_reg[31:16]);
    assign ew = biou_pkg::sat_field(rd_data_reg[47:32]);
    assign eh = biou_pkg::sat_field(rd_data_reg[63:48]);

    // overlap extents of query and entry
    logic [16:0] il, it, ir, ib, q_r, q_b, e_r, e_b, iw, ih;
    always_comb begin
        q_r = 17'(ql_reg) + 17'(qw_reg);
        q_b = 17'(qt_reg) + 17'(qh_reg);
        e_r = 17'(el) + 17'(ew);
        e_b = 17'(et) + 17'(eh);
        il  = (ql_reg > el) ? 17'(ql_reg) : 17'(el);
        it  = (qt_reg > et) ? 17'(qt_reg) : 17'(et);
        ir  = (q_r < e_r) ? q_r : e_r;
        ib  = (q_b < e_b) ? q_b : e_b;
        iw  = (ir > il) ? (ir - il) : 17'd0;
        ih  = (ib > it) ? (ib - it) : 17'd0;
    end

    // union and zero-union ratio handling
    logic [31:0] uni_sum;
    assign uni_sum = 32'(qarea_reg) + 32'(earea_reg) - 32'(inter_reg);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            biou_pkg::ST_IDLE: begin
                if (s_xfer && s_tuser == biou_pkg::OP_QUERY) begin
                    state_next = biou_pkg::ST_QAREA;
                end
            end
            biou_pkg::ST_QAREA:    state_next = biou_pkg::ST_EDGE;
            biou_pkg::ST_EDGE:     state_next = biou_pkg::ST_MUL_INT;
            biou_pkg::ST_MUL_INT:  state_next = biou_pkg::ST_MUL_AREA;
            biou_pkg::ST_MUL_AREA: state_next = biou_pkg::ST_UNION;
            biou_pkg::ST_UNION:    state_next = biou_pkg::ST_MUL_LHS;
            biou_pkg::ST_MUL_LHS:  state_next = biou_pkg::ST_MUL_RHS;
            biou_pkg::ST_MUL_RHS:  state_next = biou_pkg::ST_CMP;
            biou_pkg::ST_CMP: begin
                state_next = (cur_reg == last_reg) ? biou_pkg::ST_STORE : biou_pkg::ST_EDGE;
            end
            biou_pkg::ST_STORE: begin
                if (out_free) begin
                    state_next = biou_pkg::ST_IDLE;
                end
            end
            default:     state_next = biou_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operands
    always_comb begin
        s_tready = 1'b0;
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        case (state_reg)
            biou_pkg::ST_IDLE:     s_tready = 1'b1;
            biou_pkg::ST_QAREA: begin
                mul_a = 32'(qw_reg);
                mul_b = 32'(qh_reg);
            end
            biou_pkg::ST_MUL_INT: begin
                mul_a = 32'(iw_reg);
                mul_b = 32'(ih_reg);
            end
            biou_pkg::ST_MUL_AREA: begin
                mul_a = 32'(ew_reg);
                mul_b = 32'(eh_reg);
            end
            biou_pkg::ST_MUL_LHS: begin
                mul_a = 32'(num_reg);
                mul_b = best_den_reg;
            end
            biou_pkg::ST_MUL_RHS: begin
                mul_a = 32'(best_num_reg);
                mul_b = den_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= biou_pkg::ST_IDLE;
            region_count_reg <= 6'd32;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                region_count_reg <= cfg_wr_data;
            end
            if (state_reg == biou_pkg::ST_STORE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // table write on load transfers, registered read at the entry pointer
    always_ff @(posedge aclk) begin
        if (s_xfer && s_tuser == biou_pkg::OP_LOAD
                && 9'(in_index) < 9'(NUM_REGIONS)) begin
            region_mem[IDX_W'(in_index)] <= {in_height, in_width, in_top, in_left};
        end
        rd_data_reg <= region_mem[idx_reg];
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            biou_pkg::ST_IDLE: begin
                // capture the query and reset the entry pointer
                ql_reg   <= biou_pkg::sat_field(in_left);
                qt_reg   <= biou_pkg::sat_field(in_top);
                qw_reg   <= biou_pkg::sat_field(in_width);
                qh_reg   <= biou_pkg::sat_field(in_height);
                idx_reg  <= '0;
                last_reg <= IDX_W'(count_eff - CNT_W'(1));
            end
            biou_pkg::ST_QAREA: begin
                qarea_reg <= mul_p[30:0];
            end
            biou_pkg::ST_EDGE: begin
                // overlap extents; step the pointer so the next entry is read meanwhile
                ew_reg  <= ew;
                eh_reg  <= eh;
                iw_reg  <= iw;
                ih_reg  <= ih;
                cur_reg <= idx_reg;
                if (idx_reg != last_reg) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            biou_pkg::ST_MUL_INT: begin
                inter_reg <= mul_p[30:0];
            end
            biou_pkg::ST_MUL_AREA: begin
                earea_reg <= mul_p[30:0];
            end
            biou_pkg::ST_UNION: begin
                uni_reg <= uni_sum;
                num_reg <= (uni_sum == 32'd0) ? 31'd0 : inter_reg;
                den_reg <= (uni_sum == 32'd0) ? 32'd1 : uni_sum;
            end
            biou_pkg::ST_MUL_LHS: begin
                lhs_reg <= mul_p[62:0];
            end
            biou_pkg::ST_MUL_RHS: begin
                rhs_reg <= mul_p[62:0];
            end
            biou_pkg::ST_CMP: begin
                // first entry always taken, later ones only on a strictly greater ratio
                if (cur_reg == '0 || lhs_reg > rhs_reg) begin
                    best_reg     <= cur_reg;
                    best_int_reg <= inter_reg;
                    best_uni_reg <= uni_reg;
                    best_num_reg <= num_reg;
                    best_den_reg <= den_reg;
                end
            end
            biou_pkg::ST_STORE: begin
                if (out_free) begin
                    out_data_reg <= {best_uni_reg, best_int_reg, 5'(best_reg)};
                end
            end
            default: begin
                rhs_reg <= rhs_reg;
            end
        endcase
    end

    // entry under work never runs past the last entry of the query
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == biou_pkg::ST_MUL_INT || state_reg == biou_pkg::ST_CMP
            || state_reg == biou_pkg::ST_STORE) |-> cur_reg <= last_reg)
        else $error("entry pointer beyond last entry");

    // the chosen entry lies within the compared range
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == biou_pkg::ST_STORE |-> best_reg <= last_reg)
        else $error("best entry outside compared range");

    // union never smaller than intersection
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == biou_pkg::ST_MUL_LHS |-> uni_reg >= 32'(inter_reg))
        else $error("union below intersection");

    // a finished query lands in the output register once it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == biou_pkg::ST_STORE && out_free) |=>
            (m_valid_reg && state_reg == biou_pkg::ST_IDLE))
        else $error("result not presented after store");

endmodule
